// ===== rtl/fskut_pkg.sv =====
// fskut_pkg: shared types, constants and frame bit helper for the fsk uart transmitter
// no dependencies; used by the interfaces, the frame queue and the top level
package fskut_pkg;

   // frame layout: start, eight data bits lsb first, even parity, stop
   localparam int FRAME_BITS = 11;
   localparam int BIT_IDX_W  = 4;
   localparam logic [BIT_IDX_W-1:0] BIT_IDX_LAST = BIT_IDX_W'(FRAME_BITS - 1);

   // payload widths
   localparam int BYTE_W      = 8;
   localparam int PERIOD_W    = 16;
   localparam int CSR_INDEX_W = 8;

   // function codes of the request channel
   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MARK_PERIOD  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_SPACE_PERIOD = CSR_INDEX_W'(1);

   // register reset values
   localparam logic [PERIOD_W-1:0] MARK_PERIOD_RESET  = PERIOD_W'(177);
   localparam logic [PERIOD_W-1:0] SPACE_PERIOD_RESET = PERIOD_W'(88);

   // commands from the top level into the frame queue
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [BYTE_W-1:0] data;
   } fq_cmd_type;

   // status of the frame queue head
   typedef struct packed {
      logic nonempty;
      logic line_bit;
   } fq_status_type;

   // bit at a given position of the frame built from one byte
   function automatic logic frame_bit(input logic [BYTE_W-1:0] data,
                                      input logic [BIT_IDX_W-1:0] idx);
      logic         bit_val;
      logic [3:0]   data_sel;
      data_sel = idx - 4'd1;
      case (idx) inside
         4'd0:         bit_val = 1'b0;
         [4'd1:4'd8]:  bit_val = data[data_sel[2:0]];
         4'd9:         bit_val = ^data;
         default:      bit_val = 1'b1;
      endcase
      return bit_val;
   endfunction

endpackage

// ===== rtl/fskut_if.sv =====
// fskut channel interfaces: request, response and register write channels
// depends on fskut_pkg for payload widths
interface fskut_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [fskut_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, func, data_byte, input ready);
   modport sink   (input valid, func, data_byte, output ready);
endinterface

interface fskut_rsp_if #(parameter int COUNT_W = 9);
   logic                           valid;
   logic                           ready;
   logic                           is_tick;
   logic                           line_bit;
   logic [fskut_pkg::PERIOD_W-1:0] tone_period;
   logic                           accepted;
   logic [COUNT_W-1:0]             pending_bits;

   modport source (output valid, is_tick, line_bit, tone_period, accepted, pending_bits,
                   input ready);
   modport sink   (input valid, is_tick, line_bit, tone_period, accepted, pending_bits,
                   output ready);
endinterface

interface fskut_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fskut_pkg::CSR_INDEX_W-1:0] index;
   logic [fskut_pkg::PERIOD_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fskut_ram.sv =====
// fskut_ram: generic single write port ram with registered read
// no dependencies
module fskut_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fskut_frame_queue.sv =====
// fskut_frame_queue: queue of framed bytes popped one line bit at a time
// depends on fskut_pkg and fskut_ram; head and next frames sit in registers, the rest in ram
module fskut_frame_queue #(
   parameter int RING_BITS = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fskut_pkg::fq_cmd_type    cmd,
   output fskut_pkg::fq_status_type status
);
   import fskut_pkg::*;

   // a full bit budget holds one partial frame plus whole frames
   localparam int FRAMES_MAX = RING_BITS / FRAME_BITS + 2;
   localparam int AW         = $clog2(FRAMES_MAX);
   localparam int Q_DEPTH    = 1 << AW;

   logic [BYTE_W-1:0]    head_ff, head_in;
   logic                 head_vld_ff, head_vld_in;
   logic [BYTE_W-1:0]    next_ff, next_in;
   logic                 next_vld_ff, next_vld_in;
   logic                 fly_ff, fly_in;
   logic [BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic [AW-1:0]        wptr_ff, wptr_in;
   logic [AW-1:0]        rptr_ff, rptr_in;
   logic [AW:0]          ram_cnt_ff, ram_cnt_in;

   logic                 wr_en;
   logic                 rd_en;
   logic [BYTE_W-1:0]    rd_data;

   fskut_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (Q_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wptr_ff),
      .wr_data (cmd.data),
      .rd_en   (rd_en),
      .rd_addr (rptr_ff),
      .rd_data (rd_data)
   );

   // head status: current line bit of the oldest frame
   assign status.nonempty = head_vld_ff;
   assign status.line_bit = frame_bit(head_ff, bit_idx_ff);

   // next state of the queue
   always_comb begin
      head_in     = head_ff;
      head_vld_in = head_vld_ff;
      next_in     = next_ff;
      next_vld_in = next_vld_ff;
      bit_idx_in  = bit_idx_ff;
      wr_en       = 1'b0;

      // prefetch the next frame once its slot is free
      rd_en  = !next_vld_ff && !fly_ff && (ram_cnt_ff != '0);
      fly_in = rd_en;

      // prefetched frame lands in the next slot
      if (fly_ff) begin
         next_in     = rd_data;
         next_vld_in = 1'b1;
      end

      // new frame goes to the first free place in order
      if (cmd.push) begin
         if (!head_vld_ff) begin
            head_in     = cmd.data;
            head_vld_in = 1'b1;
         end else if (!next_vld_ff && !fly_ff && (ram_cnt_ff == '0)) begin
            next_in     = cmd.data;
            next_vld_in = 1'b1;
         end else begin
            wr_en = 1'b1;
         end
      end

      // pop one bit; the last bit retires the head frame
      if (cmd.pop && head_vld_ff) begin
         if (bit_idx_ff == BIT_IDX_LAST) begin
            bit_idx_in = '0;
            if (next_vld_ff) begin
               head_in     = next_ff;
               next_vld_in = 1'b0;
            end else begin
               head_vld_in = 1'b0;
            end
         end else begin
            bit_idx_in = bit_idx_ff + 1'b1;
         end
      end

      // ram pointers and fill
      wptr_in = wr_en ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = rd_en ? rptr_ff + 1'b1 : rptr_ff;
      case ({wr_en, rd_en})
         2'b10:   ram_cnt_in = ram_cnt_ff + 1'b1;
         2'b01:   ram_cnt_in = ram_cnt_ff - 1'b1;
         default: ram_cnt_in = ram_cnt_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         next_vld_ff <= 1'b0;
         fly_ff      <= 1'b0;
         bit_idx_ff  <= '0;
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         ram_cnt_ff  <= '0;
      end else begin
         head_vld_ff <= head_vld_in;
         next_vld_ff <= next_vld_in;
         fly_ff      <= fly_in;
         bit_idx_ff  <= bit_idx_in;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         ram_cnt_ff  <= ram_cnt_in;
      end
   end

   // frame payload registers
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      next_ff <= next_in;
   end

endmodule

// ===== rtl/fsk_uart_frame_transmitter.sv =====
// fsk_uart_frame_transmitter: top level, input register, frame queue and result register
// depends on fskut_pkg, fskut_if, fskut_frame_queue
// a request passes through the input register and then the result register before its result is offered
// throughput: one request per cycle while the response side is ready; back pressure stalls the input register
// reset clears the queue, the bit count and both pipeline valids and loads the
// default mark and space periods; no clearing pass, the queue takes requests at once
module fsk_uart_frame_transmitter #(
   parameter int RING_BITS = 256
) (
   input  logic         clock,
   input  logic         reset,
   fskut_req_if.sink    req_ch,
   fskut_rsp_if.source  rsp_ch,
   fskut_csr_if.sink    csr_ch
);
   import fskut_pkg::*;

   localparam int CW = $clog2(RING_BITS + 1);
   localparam logic [CW-1:0] FIT_MAX    = CW'(RING_BITS - FRAME_BITS);
   localparam logic [CW-1:0] FRAME_ADD  = CW'(FRAME_BITS);

   // configuration registers
   logic [PERIOD_W-1:0] mark_ff, mark_in;
   logic [PERIOD_W-1:0] space_ff, space_in;

   // input register
   logic                in_vld_ff, in_vld_in;
   logic                in_func_ff;
   logic [BYTE_W-1:0]   in_byte_ff;

   // result register
   logic                out_vld_ff, out_vld_in;
   logic                out_tick_ff, out_tick_in;
   logic                out_line_ff, out_line_in;
   logic [PERIOD_W-1:0] out_period_ff, out_period_in;
   logic                out_acc_ff, out_acc_in;
   logic [CW-1:0]       out_count_ff;

   // bits waiting in the queue
   logic [CW-1:0]       bit_count_ff, bit_count_in;

   logic                advance;
   logic                req_xfer;
   logic                fits;
   fq_cmd_type          q_cmd;
   fq_status_type       q_status;

   fskut_frame_queue #(
      .RING_BITS (RING_BITS)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .cmd    (q_cmd),
      .status (q_status)
   );

   // handshakes
   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // register writes
   always_comb begin
      mark_in  = mark_ff;
      space_in = space_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_MARK_PERIOD:  mark_in  = csr_ch.data;
            REG_SPACE_PERIOD: space_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   // per item work: enqueue a frame if it fits, or pop one line bit if the queue holds one
   assign fits = (bit_count_ff <= FIT_MAX);

   always_comb begin
      q_cmd.push    = 1'b0;
      q_cmd.pop     = 1'b0;
      q_cmd.data    = in_byte_ff;
      out_tick_in   = 1'b0;
      out_line_in   = 1'b0;
      out_period_in = '0;
      out_acc_in    = 1'b0;
      bit_count_in  = bit_count_ff;
      if (in_func_ff == FUNC_TICK) begin
         out_tick_in = 1'b1;
         if (q_status.nonempty) begin
            out_line_in  = q_status.line_bit;
            q_cmd.pop    = advance;
            bit_count_in = bit_count_ff - 1'b1;
         end else begin
            out_line_in = 1'b1;
         end
         out_period_in = out_line_in ? mark_ff : space_ff;
      end else if (fits) begin
         out_acc_in   = 1'b1;
         q_cmd.push   = advance;
         bit_count_in = bit_count_ff + FRAME_ADD;
      end
   end

   // pipeline valids
   always_comb begin
      if (req_xfer) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end

      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff      <= MARK_PERIOD_RESET;
         space_ff     <= SPACE_PERIOD_RESET;
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         bit_count_ff <= '0;
      end else begin
         mark_ff    <= mark_in;
         space_ff   <= space_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            bit_count_ff <= bit_count_in;
         end
      end
   end

   // input payload on request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff <= req_ch.func;
         in_byte_ff <= req_ch.data_byte;
      end
   end

   // result payload when an item is processed
   always_ff @(posedge clock) begin
      if (advance) begin
         out_tick_ff   <= out_tick_in;
         out_line_ff   <= out_line_in;
         out_period_ff <= out_period_in;
         out_acc_ff    <= out_acc_in;
         out_count_ff  <= bit_count_in;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.is_tick      = out_tick_ff;
   assign rsp_ch.line_bit     = out_line_ff;
   assign rsp_ch.tone_period  = out_period_ff;
   assign rsp_ch.accepted     = out_acc_ff;
   assign rsp_ch.pending_bits = out_count_ff;

endmodule
